/* hdl/eqtb_pkg.sv */
// Shared types and codes for the event queue with timer bank.
`timescale 1ns / 1ps
package eqtb_pkg;

	typedef enum logic [3:0] {
		ACT_POST      = 4'd0,
		ACT_GET       = 4'd1,
		ACT_PEEK      = 4'd2,
		ACT_TSTART    = 4'd3,
		ACT_TRESTART  = 4'd4,
		ACT_TCANCEL   = 4'd5,
		ACT_TPAUSE    = 4'd6,
		ACT_TICK      = 4'd7,
		ACT_VCREATE   = 4'd8,
		ACT_VSET      = 4'd9,
		ACT_VTOGGLE   = 4'd10,
		ACT_VREAD     = 4'd11
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EXEC,
		ST_SCAN_RD,
		ST_SCAN_EX
	} back_state_t;

	localparam logic [1:0] REG_TIMER_CODE = 2'd0;
	localparam logic [1:0] REG_VALUE_CODE = 2'd1;
	localparam logic [1:0] REG_IDLE_CODE  = 2'd2;

	typedef struct packed {
		logic [3:0]  action;
		logic [15:0] post_type;
		logic [15:0] post_arg_first;
		logic [15:0] post_arg_second;
		logic [7:0]  slot;
		logic [31:0] interval;
		logic        rep;
		logic [15:0] new_value;
		logic        tvalid;
		logic        vvalid;
	} cmd_t;

	typedef struct packed {
		logic [15:0] timer_code;
		logic [15:0] value_code;
		logic [15:0] idle_code;
	} cfg_t;

	typedef struct packed {
		logic [15:0] out_type;
		logic [15:0] arg_first;
		logic [15:0] arg_second;
		logic        ok;
		logic [15:0] read_value;
	} result_t;

endpackage

/* hdl/eqtb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module eqtb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

/* hdl/eqtb_front.sv */
// Front end: take commands, classify ids, and hold them in a two-entry queue.
`timescale 1ns / 1ps
module eqtb_front import eqtb_pkg::*; #(
	parameter int TIMER_COUNT = 8,
	parameter int VALUE_COUNT = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [3:0]  action,
	input  logic [15:0] post_type,
	input  logic [15:0] post_arg_first,
	input  logic [15:0] post_arg_second,
	input  logic [7:0]  slot_id,
	input  logic [31:0] interval_ms,
	input  logic        repeat_flag,
	input  logic [15:0] new_value,
	output logic        busy,
	output logic        cmd_valid,
	output cmd_t        cmd_head,
	input  logic        cmd_pop
);
	cmd_t       ent_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] cnt_q;
	cmd_t       cmd_in;
	logic       push;

	always_comb begin
		cmd_in.action          = action;
		cmd_in.post_type       = post_type;
		cmd_in.post_arg_first  = post_arg_first;
		cmd_in.post_arg_second = post_arg_second;
		cmd_in.slot            = slot_id;
		cmd_in.interval        = interval_ms;
		cmd_in.rep             = repeat_flag;
		cmd_in.new_value       = new_value;
		cmd_in.tvalid          = {1'b0, slot_id} < 9'(TIMER_COUNT);
		cmd_in.vvalid          = {1'b0, slot_id} < 9'(VALUE_COUNT);
	end

	assign busy      = (cnt_q == 2'd2);
	assign push      = start && !busy;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd_head  = ent_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (cmd_pop) begin
				rptr_q <= ~rptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, cmd_pop};
		end
	end
endmodule

/* hdl/eqtb_back.sv */
// Back end: run queued commands against the ring, timer bank and value store.
`timescale 1ns / 1ps
module eqtb_back import eqtb_pkg::*; #(
	parameter int QUEUE_DEPTH = 16,
	parameter int TIMER_COUNT = 8,
	parameter int VALUE_COUNT = 8
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    cmd_valid,
	input  cmd_t    cmd_head,
	output logic    cmd_pop,
	output logic    res_valid,
	output result_t res
);
	localparam int QW = $clog2(QUEUE_DEPTH);
	localparam int TW = TIMER_COUNT > 1 ? $clog2(TIMER_COUNT) : 1;
	localparam int VW = VALUE_COUNT > 1 ? $clog2(VALUE_COUNT) : 1;
	localparam int TWORD = 65;

	back_state_t state_q, state_d;
	cmd_t        cmd_q;
	logic [TW-1:0] scan_q, scan_d;
	logic [QW-1:0] wr_q, wr_d, rd_q, rd_d;
	logic [31:0]   now_q, now_d;
	logic [TIMER_COUNT-1:0] tvld_q;
	logic [VALUE_COUNT-1:0] vvld_q;

	logic          scanning;
	logic [TW-1:0] t_addr;
	logic [VW-1:0] v_addr;
	logic [47:0]   ring_rd, ring_wd;
	logic          ring_we;
	logic [TWORD-1:0] t_rd_raw, t_wd;
	logic          t_we;
	logic [15:0]   v_rd_raw, v_rd, v_wd;
	logic          v_we;
	logic [31:0]   dl, per;
	logic          rearm;
	logic          enq;
	logic [47:0]   enq_data;
	logic          due;
	logic          res_fire;
	result_t       res_d;

	function automatic logic [QW-1:0] nxt(input logic [QW-1:0] i);
		return (i == QW'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	assign scanning = (state_q == ST_SCAN_RD) || (state_q == ST_SCAN_EX);
	assign t_addr   = scanning ? scan_q : cmd_q.slot[TW-1:0];
	assign v_addr   = cmd_q.slot[VW-1:0];
	assign cmd_pop  = (state_q == ST_IDLE) && cmd_valid;

	eqtb_ram #(.WIDTH(48), .DEPTH(QUEUE_DEPTH)) u_ring (
		.clk(clk), .we(ring_we), .waddr(wr_q), .wdata(ring_wd),
		.raddr(rd_q), .rdata(ring_rd)
	);
	eqtb_ram #(.WIDTH(TWORD), .DEPTH(TIMER_COUNT)) u_timer (
		.clk(clk), .we(t_we), .waddr(t_addr), .wdata(t_wd),
		.raddr(t_addr), .rdata(t_rd_raw)
	);
	eqtb_ram #(.WIDTH(16), .DEPTH(VALUE_COUNT)) u_value (
		.clk(clk), .we(v_we), .waddr(v_addr), .wdata(v_wd),
		.raddr(v_addr), .rdata(v_rd_raw)
	);

	// never-written entries read as zero
	always_comb begin
		if (tvld_q[t_addr]) begin
			dl    = t_rd_raw[64:33];
			per   = t_rd_raw[32:1];
			rearm = t_rd_raw[0];
		end else begin
			dl    = '0;
			per   = '0;
			rearm = 1'b0;
		end
		v_rd = vvld_q[v_addr] ? v_rd_raw : 16'd0;
		due  = (dl != 32'd0) && (dl <= now_q);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					state_d = ST_READ;
				end
			end
			ST_READ:    state_d = ST_EXEC;
			ST_EXEC: begin
				if (cmd_q.action == ACT_GET && rd_q == wr_q) begin
					state_d = ST_SCAN_RD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_SCAN_RD: state_d = ST_SCAN_EX;
			ST_SCAN_EX: begin
				if (scan_q == TW'(TIMER_COUNT - 1)) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_SCAN_RD;
				end
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	// datapath and outputs
	always_comb begin
		enq      = 1'b0;
		enq_data = '0;
		t_we     = 1'b0;
		t_wd     = {dl, per, rearm};
		v_we     = 1'b0;
		v_wd     = v_rd;
		rd_d     = rd_q;
		now_d    = now_q;
		scan_d   = scan_q;
		res_fire = 1'b0;
		res_d    = '0;
		unique case (state_q)
			ST_EXEC: begin
				res_fire = 1'b1;
				case (cmd_q.action)
					ACT_POST: begin
						enq      = 1'b1;
						enq_data = {cmd_q.post_type, cmd_q.post_arg_first,
							cmd_q.post_arg_second};
						res_d.ok = 1'b1;
					end
					ACT_GET, ACT_PEEK: begin
						if (rd_q != wr_q) begin
							res_d.out_type   = ring_rd[47:32];
							res_d.arg_first  = ring_rd[31:16];
							res_d.arg_second = ring_rd[15:0];
							res_d.ok         = 1'b1;
							if (cmd_q.action == ACT_GET) begin
								rd_d = nxt(rd_q);
							end
						end else if (cmd_q.action == ACT_GET) begin
							res_fire = 1'b0;
							scan_d   = '0;
						end else begin
							res_d.out_type = cfg.idle_code;
						end
					end
					ACT_TSTART: begin
						t_we     = cmd_q.tvalid;
						t_wd     = {now_q + cmd_q.interval, cmd_q.interval, cmd_q.rep};
						res_d.ok = cmd_q.tvalid;
					end
					ACT_TRESTART: begin
						t_we     = cmd_q.tvalid;
						t_wd     = {now_q + per, per, rearm};
						res_d.ok = cmd_q.tvalid;
					end
					ACT_TCANCEL: begin
						t_we     = cmd_q.tvalid;
						t_wd     = '0;
						res_d.ok = cmd_q.tvalid;
					end
					ACT_TPAUSE: begin
						t_we     = cmd_q.tvalid;
						t_wd     = {32'd0, per, rearm};
						res_d.ok = cmd_q.tvalid;
					end
					ACT_TICK: begin
						now_d    = now_q + cmd_q.interval;
						res_d.ok = 1'b1;
					end
					ACT_VCREATE: begin
						v_we     = cmd_q.vvalid;
						v_wd     = cmd_q.new_value;
						res_d.ok = cmd_q.vvalid;
					end
					ACT_VSET: begin
						if (cmd_q.vvalid && v_rd != cmd_q.new_value) begin
							v_we     = 1'b1;
							v_wd     = cmd_q.new_value;
							enq      = 1'b1;
							enq_data = {cfg.value_code, 8'd0, cmd_q.slot, cmd_q.new_value};
						end
						res_d.ok = cmd_q.vvalid;
					end
					ACT_VTOGGLE: begin
						v_we     = cmd_q.vvalid;
						v_wd     = (v_rd == 16'd0) ? 16'd1 : 16'd0;
						enq      = cmd_q.vvalid;
						enq_data = {cfg.value_code, 8'd0, cmd_q.slot,
							((v_rd == 16'd0) ? 16'd1 : 16'd0)};
						res_d.ok = cmd_q.vvalid;
					end
					ACT_VREAD: begin
						res_d.ok         = cmd_q.vvalid;
						res_d.read_value = cmd_q.vvalid ? v_rd : 16'hFFFF;
					end
					default: ;
				endcase
			end
			ST_SCAN_EX: begin
				if (due) begin
					enq      = 1'b1;
					enq_data = {cfg.timer_code, 16'(scan_q), 16'(now_q - dl)};
					t_we     = 1'b1;
					t_wd     = {(rearm ? now_q + per : 32'd0), per, rearm};
				end
				scan_d = scan_q + 1'b1;
				if (scan_q == TW'(TIMER_COUNT - 1)) begin
					res_fire       = 1'b1;
					res_d.out_type = cfg.idle_code;
				end
			end
			default: ;
		endcase
		ring_we = enq;
		ring_wd = enq_data;
		wr_d    = enq ? nxt(wr_q) : wr_q;
		// full ring: drop the oldest event
		if (enq && nxt(wr_q) == rd_q) begin
			rd_d = nxt(rd_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd_head;
		end
		if (res_fire) begin
			res <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			scan_q    <= '0;
			wr_q      <= '0;
			rd_q      <= '0;
			now_q     <= '0;
			tvld_q    <= '0;
			vvld_q    <= '0;
			res_valid <= 1'b0;
		end else begin
			state_q   <= state_d;
			scan_q    <= scan_d;
			wr_q      <= wr_d;
			rd_q      <= rd_d;
			now_q     <= now_d;
			res_valid <= res_fire;
			if (t_we) begin
				tvld_q[t_addr] <= 1'b1;
			end
			if (v_we) begin
				vvld_q[v_addr] <= 1'b1;
			end
		end
	end
endmodule

/* hdl/event_queue_with_timer_bank.sv */
// Top level: event queue with timer bank, command port and register port.
`timescale 1ns / 1ps
// Flow: a command taken on start is popped when the back end is free (pop,
//   RAM read, execute); the back end takes no new command until the last
//   one is done, reading and then executing on the single-port-read RAMs;
//   get on an empty ring then scans every timer id, one timer read per id
//   and one timer update for each due timer.
// Reset: arst_n clears ring pointers, time, timer and value valid bits and
//   sets the code registers to their defaults at once; results are strobed by done and cannot be stalled.
module event_queue_with_timer_bank import eqtb_pkg::*; #(
	parameter int QUEUE_DEPTH = 16,
	parameter int TIMER_COUNT = 8,
	parameter int VALUE_COUNT = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	// command beat
	input  logic               start,
	output logic               busy,
	input  logic [3:0]         action,
	input  logic signed [15:0] post_type,
	input  logic signed [15:0] post_arg_first,
	input  logic signed [15:0] post_arg_second,
	input  logic [7:0]         slot_id,
	input  logic [31:0]        interval_ms,
	input  logic               repeat_flag,
	input  logic signed [15:0] new_value,
	// result beat
	output logic               done,
	output logic signed [15:0] out_type,
	output logic signed [15:0] out_arg_first,
	output logic signed [15:0] out_arg_second,
	output logic               ok,
	output logic signed [15:0] read_value,
	// register port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	cfg_t    cfg_q;
	logic    cmd_valid, cmd_pop;
	cmd_t    cmd_head;
	result_t res;
	logic    wr_en;

	// Register file: three 16-bit codes at word-aligned byte addresses.
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timer_code <= 16'd1;
			cfg_q.value_code <= 16'd2;
			cfg_q.idle_code  <= 16'd0;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_TIMER_CODE: cfg_q.timer_code <= pwdata[15:0];
				REG_VALUE_CODE: cfg_q.value_code <= pwdata[15:0];
				REG_IDLE_CODE:  cfg_q.idle_code  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_TIMER_CODE: prdata = {16'd0, cfg_q.timer_code};
			REG_VALUE_CODE: prdata = {16'd0, cfg_q.value_code};
			REG_IDLE_CODE:  prdata = {16'd0, cfg_q.idle_code};
			default:        prdata = 32'd0;
		endcase
	end

	// Front end: hold up to two classified commands.
	eqtb_front #(.TIMER_COUNT(TIMER_COUNT), .VALUE_COUNT(VALUE_COUNT)) u_front (
		.clk(clk), .arst_n(arst_n), .start(start),
		.action(action), .post_type(post_type),
		.post_arg_first(post_arg_first), .post_arg_second(post_arg_second),
		.slot_id(slot_id), .interval_ms(interval_ms),
		.repeat_flag(repeat_flag), .new_value(new_value),
		.busy(busy), .cmd_valid(cmd_valid), .cmd_head(cmd_head), .cmd_pop(cmd_pop)
	);

	// Back end: execute in order and drive the registered result.
	eqtb_back #(
		.QUEUE_DEPTH(QUEUE_DEPTH), .TIMER_COUNT(TIMER_COUNT), .VALUE_COUNT(VALUE_COUNT)
	) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.cmd_valid(cmd_valid), .cmd_head(cmd_head), .cmd_pop(cmd_pop),
		.res_valid(done), .res(res)
	);

	assign out_type       = res.out_type;
	assign out_arg_first  = res.arg_first;
	assign out_arg_second = res.arg_second;
	assign ok             = res.ok;
	assign read_value     = res.read_value;
endmodule

/* hdl/eqtb_checker.sv */
// Port-level checks for the event queue with timer bank, bound to the top level.
`timescale 1ns / 1ps
module eqtb_props (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic               ok,
	input logic signed [15:0] out_arg_first,
	input logic signed [15:0] out_arg_second,
	input logic signed [15:0] read_value,
	input logic               pready
);
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("results on back-to-back cycles");

	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a command beat");

	a_args_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && (out_arg_first != 16'sd0 || out_arg_second != 16'sd0) |-> ok)
		else $error("event arguments without ok");

	a_value_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && read_value != 16'sd0 && read_value != -16'sd1 |-> ok)
		else $error("read value without ok");
endmodule

bind event_queue_with_timer_bank eqtb_props u_eqtb_props (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done), .ok(ok),
	.out_arg_first(out_arg_first), .out_arg_second(out_arg_second),
	.read_value(read_value), .pready(pready)
);
